/* hdl/fp16pa_pkg.sv */
// Package with the transaction types and constants of the binary16 pair adder.
`timescale 1ns / 1ps
package fp16pa_pkg;

    localparam logic [15:0] QNAN16 = 16'h7E00;
    localparam logic [4:0]  EXP_MAX = 5'd31;

    typedef struct packed {
        logic [15:0] a_low_lane;
        logic [15:0] a_high_lane;
        logic [15:0] b_low_lane;
        logic [15:0] b_high_lane;
    } fp16pa_in_t;

    typedef struct packed {
        logic [15:0] sum_low_lane;
        logic [15:0] sum_high_lane;
    } fp16pa_out_t;

    // Stage 1 to stage 2: aligned operands of one lane.
    typedef struct packed {
        logic        special;
        logic [15:0] special_val;
        logic        sign_big;
        logic        sign_small;
        logic        eff_sub;
        logic [4:0]  exp_big;
        logic [10:0] sig_big;
        logic [13:0] sig_small;   // aligned, with guard, round, sticky
        logic        both_zero_same;
        logic        sign_a;
    } fp16pa_align_t;

    // Stage 2 to stage 3: raw sum and its leading one position.
    typedef struct packed {
        logic        special;
        logic [15:0] special_val;
        logic        sign;
        logic [4:0]  exp_big;
        logic [14:0] mag;         // bit 14 carry, bits 2..0 guard, round, sticky
        logic        zero;
        logic [15:0] zero_val;
        logic [3:0]  lead;        // position of the leading one in mag
    } fp16pa_sum_t;

    // Stage 3 to stage 4: normalized significand ready to round.
    typedef struct packed {
        logic        special;
        logic [15:0] special_val;
        logic        sign;
        logic [5:0]  exp;
        logic [13:0] norm;        // bit 13 hidden bit, bits 2..0 guard, round, sticky
    } fp16pa_norm_t;

endpackage

/* hdl/fp16pa_lane.sv */
// One binary16 adder lane cut into align, add, normalize and round stages.
`timescale 1ns / 1ps
module fp16pa_lane (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [15:0] sum
);
    import fp16pa_pkg::*;

    fp16pa_align_t s1_next, s1_reg;
    fp16pa_sum_t   s2_next, s2_reg;
    fp16pa_norm_t  s3_next, s3_reg;
    logic [15:0]   s4_next, s4_reg;

    // Align: unpack, handle specials, shift the smaller operand right.
    always_comb
    begin
        logic        sa, sb, swap, a_nan, b_nan, a_inf, b_inf;
        logic [4:0]  ea, eb, diff;
        logic [10:0] ga, gb, gs;
        logic [24:0] wide;
        sa = a[15];
        sb = b[15];
        ea = (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
        eb = (b[14:10] == 5'd0) ? 5'd1 : b[14:10];
        ga = {a[14:10] != 5'd0, a[9:0]};
        gb = {b[14:10] != 5'd0, b[9:0]};
        a_nan = (a[14:10] == EXP_MAX) && (a[9:0] != 10'd0);
        b_nan = (b[14:10] == EXP_MAX) && (b[9:0] != 10'd0);
        a_inf = (a[14:10] == EXP_MAX) && (a[9:0] == 10'd0);
        b_inf = (b[14:10] == EXP_MAX) && (b[9:0] == 10'd0);
        swap = {eb, gb} > {ea, ga};
        s1_next.special = a_nan || b_nan || a_inf || b_inf;
        if (a_nan || b_nan || (a_inf && b_inf && (sa != sb)))
            s1_next.special_val = QNAN16;
        else if (a_inf)
            s1_next.special_val = {sa, EXP_MAX, 10'd0};
        else
            s1_next.special_val = {sb, EXP_MAX, 10'd0};
        s1_next.sign_big   = swap ? sb : sa;
        s1_next.sign_small = swap ? sa : sb;
        s1_next.eff_sub    = sa != sb;
        s1_next.exp_big    = swap ? eb : ea;
        s1_next.sig_big    = swap ? gb : ga;
        gs   = swap ? ga : gb;
        diff = swap ? (eb - ea) : (ea - eb);
        wide = {gs, 14'd0} >> diff;
        s1_next.sig_small = {wide[24:12], wide[11:0] != 12'd0};
        s1_next.both_zero_same = (sa == sb);
        s1_next.sign_a = sa;
    end

    // Add or subtract and find the leading one.
    always_comb
    begin
        logic [14:0] big, m;
        big = {1'b0, s1_reg.sig_big, 3'd0};
        if (s1_reg.eff_sub)
            m = big - {1'b0, s1_reg.sig_small};
        else
            m = big + {1'b0, s1_reg.sig_small};
        s2_next.special     = s1_reg.special;
        s2_next.special_val = s1_reg.special_val;
        s2_next.sign        = s1_reg.sign_big;
        s2_next.exp_big     = s1_reg.exp_big;
        s2_next.mag         = m;
        s2_next.zero        = m == 15'd0;
        s2_next.zero_val    = s1_reg.both_zero_same ? {s1_reg.sign_a, 15'd0} : 16'd0;
        s2_next.lead        = 4'd0;
        for (int i = 0; i < 15; i++)
            if (m[i])
                s2_next.lead = 4'(i);
    end

    // Normalize: exponent becomes exp_big + lead - 13, clamped at 1.
    always_comb
    begin
        logic signed [6:0] e;
        logic [3:0]        sh;
        logic [28:0]       t;
        sh = 4'd0;
        t  = 29'd0;
        e = 7'(s2_reg.exp_big) + 7'(s2_reg.lead) - 7'sd13;
        s3_next.special     = s2_reg.special || s2_reg.zero;
        s3_next.special_val = s2_reg.special ? s2_reg.special_val : s2_reg.zero_val;
        s3_next.sign        = s2_reg.sign;
        if (s2_reg.lead == 4'd14)
        begin
            s3_next.exp  = 6'(s2_reg.exp_big) + 6'd1;
            s3_next.norm = {s2_reg.mag[14:2], s2_reg.mag[1] | s2_reg.mag[0]};
        end
        else
        begin
            if (e < 7'sd1)
            begin
                s3_next.exp = 6'd1;
                sh = 4'(s2_reg.exp_big - 5'd1);
            end
            else
            begin
                s3_next.exp = 6'(e);
                sh = 4'd13 - s2_reg.lead;
            end
            t = {s2_reg.mag, 14'd0} << sh;
            s3_next.norm = t[27:14];
        end
    end

    // Round to nearest even and pack.
    always_comb
    begin
        logic [11:0] q;
        logic        up;
        logic [5:0]  e;
        up = s3_reg.norm[2] && (s3_reg.norm[1] || s3_reg.norm[0] || s3_reg.norm[3]);
        q  = {1'b0, s3_reg.norm[13:3]} + 12'(up);
        e  = s3_reg.exp;
        if (q[11])
        begin
            q = q >> 1;
            e = e + 6'd1;
        end
        if (s3_reg.special)
            s4_next = s3_reg.special_val;
        else if (e >= 6'd31)
            s4_next = {s3_reg.sign, EXP_MAX, 10'd0};
        else if (!q[10])
            s4_next = {s3_reg.sign, 5'd0, q[9:0]};
        else
            s4_next = {s3_reg.sign, e[4:0], q[9:0]};
    end

    logic [2:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 3'd0;
        else
            v_reg <= {v_reg[1:0], valid};
    end

    // Payload stages load only behind a valid transaction.
    always_ff @(posedge clk)
    begin
        if (valid)     s1_reg <= s1_next;
        if (v_reg[0])  s2_reg <= s2_next;
        if (v_reg[1])  s3_reg <= s3_next;
        if (v_reg[2])  s4_reg <= s4_next;
    end

    assign sum = s4_reg;

endmodule

/* hdl/fp16_pair_adder.sv */
// Top level of the two-lane binary16 adder.
`timescale 1ns / 1ps
// Adds two pairs of IEEE binary16 values with round to nearest even, full
// subnormal, infinity and NaN handling (NaN results are 0x7E00). A transaction
// is taken in every cycle that start is high; busy is always low. Each result
// is marked by done for one cycle and leaves the four-stage align, add,
// normalize and round pipeline, whose stages are each registered. The
// receiver cannot stall, so the results must be captured when done is high.
module fp16_pair_adder (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  fp16pa_pkg::fp16pa_in_t  operands,
    output logic                    done,
    output fp16pa_pkg::fp16pa_out_t sums
);
    import fp16pa_pkg::*;

    logic [3:0] valid_reg;
    logic       take;

    assign busy = 1'b0;
    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 4'd0;
        else
            valid_reg <= {valid_reg[2:0], take};
    end

    assign done = valid_reg[3];

    fp16pa_lane u_lane_low (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (take),
        .a     (operands.a_low_lane),
        .b     (operands.b_low_lane),
        .sum   (sums.sum_low_lane)
    );

    fp16pa_lane u_lane_high (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (take),
        .a     (operands.a_high_lane),
        .b     (operands.b_high_lane),
        .sum   (sums.sum_high_lane)
    );

endmodule

/* hdl/fp16pa_checker.sv */
// Port-level assertions for the binary16 pair adder, bound to the top level.
`timescale 1ns / 1ps
module fp16pa_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    import fp16pa_pkg::*;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("transaction produced no result after four cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without a matching transaction");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised on a pipeline that never stalls");

endmodule

bind fp16_pair_adder fp16pa_checker u_fp16pa_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
